/* rtl/sgt_pkg.sv */
// Shared types and constants for the serial gap tracker.
// No dependencies; imported by every module of the block.
package sgt_pkg;

   localparam int SERIAL_W = 14;
   localparam int STATUS_W = 3;

   localparam logic [STATUS_W-1:0] ST_IN_ORDER  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_GAP       = 3'd2;
   localparam logic [STATUS_W-1:0] ST_RECOVERED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_RESYNC    = 3'd4;

   // Command broadcast from the sequencer to every cell of the set.
   typedef struct packed {
      logic                shift;     // move every entry one cell toward the head
      logic                load;      // write ins_data into the selected cell
      logic [SERIAL_W-1:0] ins_data;
   } sgt_ctrl_type;

endpackage

/* rtl/sgt_cell.sv */
// One cell of the outstanding-serial row: holds a single serial.
// Depends on sgt_pkg.
module sgt_cell
   import sgt_pkg::*;
(
   input  logic                clock,
   input  sgt_ctrl_type        ctrl,
   input  logic                sel,
   input  logic [SERIAL_W-1:0] neighbor_data,
   output logic [SERIAL_W-1:0] entry
);

   logic [SERIAL_W-1:0] entry_ff;
   logic [SERIAL_W-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.load && sel) begin
         entry_in = ctrl.ins_data;
      end else if (ctrl.shift) begin
         entry_in = neighbor_data;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

/* rtl/sgt_chain.sv */
// Row of sgt_cell instances forming the outstanding-serial set.
// Depends on sgt_pkg and sgt_cell; cell 0 is the head.
module sgt_chain
   import sgt_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int IDX_W = 6
) (
   input  logic                clock,
   input  sgt_ctrl_type        ctrl,
   input  logic [IDX_W-1:0]    load_idx,
   output logic [SERIAL_W-1:0] head
);

   logic [SERIAL_W-1:0] entries [DEPTH];
   logic [SERIAL_W-1:0] neighbors [DEPTH];
   logic [DEPTH-1:0]    sel;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      // Decode the target cell locally and feed each cell from its upstream neighbor.
      assign sel[i] = (load_idx == IDX_W'(i));
      if (i == DEPTH - 1) begin : g_last
         assign neighbors[i] = '0;
      end else begin : g_mid
         assign neighbors[i] = entries[i+1];
      end
      sgt_cell u_cell (
         .clock         (clock),
         .ctrl          (ctrl),
         .sel           (sel[i]),
         .neighbor_data (neighbors[i]),
         .entry         (entries[i])
      );
   end

   assign head = entries[0];

endmodule

/* rtl/serial_gap_tracker_top.sv */
// Serial gap tracker top level: APB registers, item sequencer, outstanding row.
// Depends on sgt_pkg and sgt_chain (which instantiates sgt_cell).
//
// An out-of-range serial gives its result in the cycle after start, busy stays low.
// Otherwise busy covers the set walk, the decision and, on a gap, the fill of each
// missing serial; a recovered serial ends early. One item at a time: start is taken
// only while idle, so a new item waits out the busy period; the walk of the cell row
// and the one-entry-per-cycle fill set its length.
// Reset (synchronous): registers return to their defaults and the start values are
// applied; the set is empty. The receiver cannot stall; each result is a one-cycle beat.
module serial_gap_tracker_top
   import sgt_pkg::*;
#(
   parameter int SERIAL_MIN    = 1,
   parameter int SERIAL_MAX    = 9999,
   parameter int PENDING_DEPTH = 64
) (
   input  logic                clock,
   input  logic                reset,
   // command channel
   input  logic                start,
   output logic                busy,
   input  logic [SERIAL_W-1:0] req_serial,
   // result channel
   output logic                rsp_strobe,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SERIAL_W-1:0] rsp_gap_first,
   output logic [SERIAL_W-1:0] rsp_gap_last,
   // configuration port
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [3:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   localparam int IDX_W  = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
   localparam int CNT_W  = $clog2(PENDING_DEPTH + 1);
   localparam int DIST_W = SERIAL_W + 1;
   localparam int SUM_W  = DIST_W + 1;
   localparam int SPAN   = SERIAL_MAX - SERIAL_MIN + 1;
   localparam int HALF   = SPAN / 2;

   localparam logic [SERIAL_W-1:0] SMIN       = SERIAL_W'(SERIAL_MIN);
   localparam logic [SERIAL_W-1:0] SMAX       = SERIAL_W'(SERIAL_MAX);
   localparam logic [DIST_W-1:0]   SPAN_D     = DIST_W'(SPAN);
   localparam logic [DIST_W-1:0]   HALF_D     = DIST_W'(HALF);
   localparam logic [SUM_W-1:0]    DEPTH_S    = SUM_W'(PENDING_DEPTH);
   localparam logic [CNT_W-1:0]    DEPTH_C    = CNT_W'(PENDING_DEPTH);
   localparam logic [CNT_W-1:0]    ONE_C      = CNT_W'(1);
   localparam logic [SERIAL_W-1:0] RST_EXPECT = SERIAL_W'(1);
   localparam logic [SERIAL_W-1:0] RST_GAP    = SERIAL_W'(16);

   localparam logic [1:0] REG_START_EXPECTED = 2'd0;
   localparam logic [1:0] REG_START_SYNCED   = 2'd1;
   localparam logic [1:0] REG_MAX_GAP        = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_DECIDE,
      S_FILL
   } state_type;

   function automatic logic in_space(input logic [SERIAL_W-1:0] s);
      return (s >= SMIN) && (s <= SMAX);
   endfunction

   function automatic logic [SERIAL_W-1:0] serial_next(input logic [SERIAL_W-1:0] s);
      return (s == SMAX) ? SMIN : s + SERIAL_W'(1);
   endfunction

   function automatic logic [SERIAL_W-1:0] serial_prev(input logic [SERIAL_W-1:0] s);
      return (s == SMIN) ? SMAX : s - SERIAL_W'(1);
   endfunction

   // ---------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------
   state_type           state_ff, state_in;
   logic [SERIAL_W-1:0] start_expected_ff, start_expected_in;
   logic                start_synced_ff, start_synced_in;
   logic [SERIAL_W-1:0] max_gap_ff, max_gap_in;
   logic [SERIAL_W-1:0] expected_ff, expected_in;
   logic                synced_ff, synced_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    step_ff, step_in;
   logic [CNT_W-1:0]    remain_ff, remain_in;
   logic [SERIAL_W-1:0] serial_ff, serial_in;
   logic [DIST_W-1:0]   dist_ff, dist_in;
   logic [SERIAL_W-1:0] fill_ff, fill_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SERIAL_W-1:0] rsp_gap_first_ff, rsp_gap_first_in;
   logic [SERIAL_W-1:0] rsp_gap_last_ff, rsp_gap_last_in;

   // Cell row interface
   sgt_ctrl_type        ctrl;
   logic [IDX_W-1:0]    load_idx;
   logic [SERIAL_W-1:0] head;

   logic                cfg_wr;
   logic [SERIAL_W-1:0] wr_value;

   assign cfg_wr   = psel && penable && pwrite && pready;
   assign wr_value = pwdata[SERIAL_W-1:0];
   assign pready   = 1'b1;

   always_comb begin
      prdata = '0;
      unique case (paddr[3:2])
         REG_START_EXPECTED: prdata = 32'(start_expected_ff);
         REG_START_SYNCED:   prdata = 32'(start_synced_ff);
         REG_MAX_GAP:        prdata = 32'(max_gap_ff);
         default:            prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------------
   // Sequencer: walk the set, decide, then fill missing serials one per cycle
   // ---------------------------------------------------------------------------
   always_comb begin
      logic [SUM_W-1:0]  need;
      logic              fits;
      need              = SUM_W'(count_ff) + SUM_W'(dist_ff);
      fits              = (dist_ff <= DIST_W'(max_gap_ff)) && (need <= DEPTH_S);

      state_in          = state_ff;
      start_expected_in = start_expected_ff;
      start_synced_in   = start_synced_ff;
      max_gap_in        = max_gap_ff;
      expected_in       = expected_ff;
      synced_in         = synced_ff;
      count_in          = count_ff;
      step_in           = step_ff;
      remain_in         = remain_ff;
      serial_in         = serial_ff;
      dist_in           = dist_ff;
      fill_in           = fill_ff;
      rsp_strobe_in     = 1'b0;
      rsp_status_in     = rsp_status_ff;
      rsp_gap_first_in  = rsp_gap_first_ff;
      rsp_gap_last_in   = rsp_gap_last_ff;
      ctrl              = '0;
      load_idx          = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               serial_in = req_serial;
               if (!in_space(req_serial)) begin
                  // Out-of-range serial: report resync, leave the expected serial, sync flag and set alone.
                  rsp_strobe_in    = 1'b1;
                  rsp_status_in    = ST_RESYNC;
                  rsp_gap_first_in = '0;
                  rsp_gap_last_in  = '0;
               end else begin
                  step_in  = '0;
                  state_in = S_SEARCH;
               end
            end
         end
         S_SEARCH: begin
            if (step_ff == count_ff) begin
               // Not outstanding: register the forward distance for the decision.
               if (serial_ff >= expected_ff) begin
                  dist_in = DIST_W'(serial_ff) - DIST_W'(expected_ff);
               end else begin
                  dist_in = DIST_W'(serial_ff) + SPAN_D - DIST_W'(expected_ff);
               end
               state_in = S_DECIDE;
            end else if (head == serial_ff) begin
               // Drop the head entry: shift the row, do not reinsert.
               ctrl.shift       = 1'b1;
               count_in         = count_ff - ONE_C;
               rsp_strobe_in    = 1'b1;
               rsp_status_in    = ST_RECOVERED;
               rsp_gap_first_in = '0;
               rsp_gap_last_in  = '0;
               state_in         = S_IDLE;
            end else begin
               // Rotate: head goes back in at the tail of the occupied part.
               ctrl.shift    = 1'b1;
               ctrl.load     = 1'b1;
               ctrl.ins_data = head;
               load_idx      = IDX_W'(count_ff - ONE_C);
               step_in       = step_ff + ONE_C;
            end
         end
         S_DECIDE: begin
            rsp_gap_first_in = '0;
            rsp_gap_last_in  = '0;
            state_in         = S_IDLE;
            rsp_strobe_in    = 1'b1;
            if (!synced_ff) begin
               synced_in     = 1'b1;
               expected_in   = serial_next(serial_ff);
               rsp_status_in = ST_IN_ORDER;
            end else if (dist_ff == '0) begin
               expected_in   = serial_next(serial_ff);
               rsp_status_in = ST_IN_ORDER;
            end else if (dist_ff > HALF_D) begin
               rsp_status_in = ST_DUPLICATE;
            end else if (fits) begin
               // Hold the beat until every missing serial is in the row.
               rsp_strobe_in    = 1'b0;
               fill_in          = expected_ff;
               remain_in        = CNT_W'(dist_ff);
               rsp_gap_first_in = expected_ff;
               rsp_gap_last_in  = serial_prev(serial_ff);
               expected_in      = serial_next(serial_ff);
               state_in         = S_FILL;
            end else begin
               count_in      = '0;
               expected_in   = serial_next(serial_ff);
               rsp_status_in = ST_RESYNC;
            end
         end
         S_FILL: begin
            ctrl.load     = 1'b1;
            ctrl.ins_data = fill_ff;
            load_idx      = IDX_W'(count_ff);
            count_in      = count_ff + ONE_C;
            fill_in       = serial_next(fill_ff);
            remain_in     = remain_ff - ONE_C;
            if (remain_ff == ONE_C) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_GAP;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // User writes regs only while idle (not enforced); start regs reapply start values.
      if (cfg_wr) begin
         unique case (paddr[3:2])
            REG_START_EXPECTED: begin
               start_expected_in = wr_value;
               expected_in       = in_space(wr_value) ? wr_value : SMIN;
               synced_in         = in_space(wr_value) && start_synced_ff;
               count_in          = '0;
            end
            REG_START_SYNCED: begin
               start_synced_in = pwdata[0];
               expected_in     = in_space(start_expected_ff) ? start_expected_ff : SMIN;
               synced_in       = in_space(start_expected_ff) && pwdata[0];
               count_in        = '0;
            end
            REG_MAX_GAP: begin
               max_gap_in = wr_value;
            end
            default: begin
               max_gap_in = max_gap_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         start_expected_ff <= RST_EXPECT;
         start_synced_ff   <= 1'b0;
         max_gap_ff        <= RST_GAP;
         expected_ff       <= in_space(RST_EXPECT) ? RST_EXPECT : SMIN;
         synced_ff         <= 1'b0;
         count_ff          <= '0;
         step_ff           <= '0;
         remain_ff         <= '0;
         rsp_strobe_ff     <= 1'b0;
      end else begin
         state_ff          <= state_in;
         start_expected_ff <= start_expected_in;
         start_synced_ff   <= start_synced_in;
         max_gap_ff        <= max_gap_in;
         expected_ff       <= expected_in;
         synced_ff         <= synced_in;
         count_ff          <= count_in;
         step_ff           <= step_in;
         remain_ff         <= remain_in;
         rsp_strobe_ff     <= rsp_strobe_in;
      end
      serial_ff        <= serial_in;
      dist_ff          <= dist_in;
      fill_ff          <= fill_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_gap_first_ff <= rsp_gap_first_in;
      rsp_gap_last_ff  <= rsp_gap_last_in;
   end

   sgt_chain #(
      .DEPTH (PENDING_DEPTH),
      .IDX_W (IDX_W)
   ) u_chain (
      .clock    (clock),
      .ctrl     (ctrl),
      .load_idx (load_idx),
      .head     (head)
   );

   assign busy          = (state_ff != S_IDLE);
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_gap_first = rsp_gap_first_ff;
   assign rsp_gap_last  = rsp_gap_last_ff;

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("outstanding count exceeds the row depth");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |-> (step_ff <= count_ff))
      else $error("set walk ran past the occupied cells");

   a_beat_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result beat while an item is still in work");

   a_gap_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_GAP) |->
         (in_space(rsp_gap_first) && in_space(rsp_gap_last)))
      else $error("gap bounds outside the serial space");

   a_no_gap_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != ST_GAP) |->
         (rsp_gap_first == '0 && rsp_gap_last == '0))
      else $error("gap bounds set on a non-gap result");

endmodule
